FILE: src/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

  localparam int unsigned FRAME_TOTAL_DEF = 16384;
  localparam int unsigned CACHE_DEPTH_DEF = 16;

  localparam int unsigned ADDR_REG_W = 27;
  localparam int unsigned SCAN_W     = 16;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_ADD_REF = 3'd2;
  localparam logic [2:0] CMD_RD_REF  = 3'd3;
  localparam logic [2:0] CMD_MARK    = 3'd4;
  localparam logic [2:0] CMD_RESERVE = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic       REG_HEAP_END = 1'b0;
  localparam logic       REG_MAP_END  = 1'b1;

  localparam logic [31:0] NONE_FREE    = 32'hFFFF_FFFF;
  localparam logic [15:0] REF_MAX      = 16'hFFFF;
  localparam logic [ADDR_REG_W-1:0] HEAP_END_RST = 27'd4194304;
  localparam logic [ADDR_REG_W-1:0] MAP_END_RST  = 27'h400_0000;

endpackage

`default_nettype wire

FILE: src/page_frame_allocator.sv
// Throughput: one command in flight; the next beat is taken the cycle after the result
//   is loaded into the output register.
// Reset: synchronous active-low rst_n; then a clearing pass zeroes counts and bitmap,
//   during which no command is taken (config writes still are).
`default_nettype none

module page_frame_allocator import pfa_pkg::*; #(
  parameter int unsigned FRAME_TOTAL = FRAME_TOTAL_DEF,
  parameter int unsigned CACHE_DEPTH = CACHE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_command,
  input  wire logic [31:0]           in_address,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                out_frame_address,
  output logic [15:0]                out_ref_value,
  output logic [1:0]                 out_status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [ADDR_REG_W-1:0] cfg_data
);

  localparam int unsigned WORD_TOTAL = FRAME_TOTAL / 32;
  localparam int unsigned FW  = $clog2(FRAME_TOTAL);   // frame index bits
  localparam int unsigned WW  = FW - 5;                // bitmap word index bits
  localparam int unsigned LW  = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned SIW = $clog2(CACHE_DEPTH);
  localparam int unsigned NW  = 21;                    // frame counts up to 2^20

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_POP    = 5'd3;
  localparam logic [4:0] S_SC_CHK = 5'd4;
  localparam logic [4:0] S_SC_LD  = 5'd5;
  localparam logic [4:0] S_SC_BIT = 5'd6;
  localparam logic [4:0] S_SC_WB  = 5'd7;
  localparam logic [4:0] S_REF_RD = 5'd8;
  localparam logic [4:0] S_REF_EX = 5'd9;
  localparam logic [4:0] S_SP_POP = 5'd10;
  localparam logic [4:0] S_CL_RD  = 5'd11;
  localparam logic [4:0] S_CL_WR  = 5'd12;
  localparam logic [4:0] S_MK_RD  = 5'd13;
  localparam logic [4:0] S_MK_WR  = 5'd14;
  localparam logic [4:0] S_RV_CHK = 5'd15;
  localparam logic [4:0] S_RV_WR  = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;

  // config registers
  logic [ADDR_REG_W-1:0] heap_end_r, map_end_r;

  // control state
  logic [4:0]        state_r, state_nxt;
  logic [FW-1:0]     init_cnt_r, init_cnt_nxt;
  logic [LW-1:0]     level_r, level_nxt;
  logic [WW-1:0]     hint_r, hint_nxt;
  logic              out_valid_r, out_valid_nxt;

  // working registers
  logic [2:0]        cmd_r, cmd_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [SCAN_W-1:0] scan_w_r, scan_w_nxt;   // scan word / reserve word
  logic [4:0]        bit_r, bit_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [LW-1:0]     got_r, got_nxt;
  logic              end_r, end_nxt;
  logic [LW-1:0]     spill_r, spill_nxt;
  logic              fdone_r, fdone_nxt;
  logic [FW-1:0]     clr_f_r, clr_f_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [31:0]       res_frame_r, res_frame_nxt;
  logic [15:0]       res_ref_r, res_ref_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [31:0]       out_frame_r;
  logic [15:0]       out_ref_r;
  logic [1:0]        out_st_r;

  // frame cache
  logic [FW-1:0]     stack_r [CACHE_DEPTH];
  logic              st_we;
  logic [SIW-1:0]    st_waddr;
  logic [FW-1:0]     st_wdata;
  logic [FW-1:0]     stack_top;

  // memories
  logic [31:0]       bm_mem [WORD_TOTAL];
  logic [15:0]       ref_mem [FRAME_TOTAL];
  logic [31:0]       bm_rdata_r;
  logic [15:0]       ref_rdata_r;
  logic [WW-1:0]     bm_raddr, bm_waddr;
  logic              bm_we;
  logic [31:0]       bm_wdata;
  logic              ref_we;
  logic [FW-1:0]     ref_waddr;
  logic [15:0]       ref_wdata;

  // derived values
  logic [FW-1:0]     fidx;
  logic              f_in_range;
  logic [SCAN_W-1:0] low_w, stop_w, start_w;
  logic [FW-1:0]     scan_f;
  logic [WW-1:0]     clr_w;
  logic [NW-1:0]     rv_base, rv_rem;
  logic [31:0]       rv_mask;
  logic [32:0]       rv_sum;
  logic [NW-1:0]     rv_n;

  assign fidx       = addr_r[12 +: FW];
  assign f_in_range = {1'b0, addr_r[31:12]} < NW'(FRAME_TOTAL);
  assign low_w      = SCAN_W'(heap_end_r >> 17);
  assign start_w    = (SCAN_W'(hint_r) < low_w) ? low_w : SCAN_W'(hint_r);
  assign stop_w     = (SCAN_W'(map_end_r >> 17) > SCAN_W'(WORD_TOTAL)) ?
                      SCAN_W'(WORD_TOTAL) : SCAN_W'(map_end_r >> 17);
  assign scan_f     = {scan_w_r[WW-1:0], bit_r};
  assign clr_w      = clr_f_r[FW-1:5];
  assign stack_top  = stack_r[SIW'(level_r - LW'(1))];
  assign rv_sum     = {1'b0, addr_r} + 33'd4095;
  assign rv_n       = (rv_sum[32:12] > NW'(FRAME_TOTAL)) ? NW'(FRAME_TOTAL) : rv_sum[32:12];
  assign rv_base    = NW'({scan_w_r, 5'b0});
  assign rv_rem     = n_r - rv_base;
  assign rv_mask    = (rv_rem >= NW'(32)) ? 32'hFFFF_FFFF : ((32'h1 << rv_rem[4:0]) - 32'h1);

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_frame_r;
  assign out_ref_value     = out_ref_r;
  assign out_status        = out_st_r;
  assign cfg_ready         = 1'b1;

  // bitmap read address: one port shared by scan, clear, mark and reserve
  always_comb begin
    case (state_r)
      S_CL_RD:  bm_raddr = clr_w;
      S_MK_RD:  bm_raddr = fidx[FW-1:5];
      default:  bm_raddr = scan_w_r[WW-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    level_nxt     = level_r;
    hint_nxt      = hint_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    scan_w_nxt    = scan_w_r;
    bit_nxt       = bit_r;
    word_nxt      = word_r;
    got_nxt       = got_r;
    end_nxt       = end_r;
    spill_nxt     = spill_r;
    fdone_nxt     = fdone_r;
    clr_f_nxt     = clr_f_r;
    n_nxt         = n_r;
    res_frame_nxt = res_frame_r;
    res_ref_nxt   = res_ref_r;
    res_st_nxt    = res_st_r;
    st_we         = 1'b0;
    st_waddr      = level_r[SIW-1:0];
    st_wdata      = scan_f;
    bm_we         = 1'b0;
    bm_waddr      = scan_w_r[WW-1:0];
    bm_wdata      = word_r;
    ref_we        = 1'b0;
    ref_waddr     = fidx;
    ref_wdata     = 16'd1;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        ref_we    = 1'b1;
        ref_waddr = init_cnt_r;
        ref_wdata = 16'd0;
        if (init_cnt_r < FW'(WORD_TOTAL)) begin
          bm_we    = 1'b1;
          bm_waddr = init_cnt_r[WW-1:0];
          bm_wdata = 32'd0;
        end
        init_cnt_nxt = init_cnt_r + FW'(1);
        if (init_cnt_r == FW'(FRAME_TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          addr_nxt  = in_address;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_frame_nxt = 32'd0;
        res_ref_nxt   = 16'd0;
        res_st_nxt    = ST_DONE;
        state_nxt     = S_FIN;
        case (cmd_r) inside
          CMD_ALLOC: begin
            if (level_r != LW'(0)) begin
              state_nxt = S_POP;
            end else begin
              scan_w_nxt = start_w;
              got_nxt    = LW'(0);
              end_nxt    = 1'b0;
              state_nxt  = S_SC_CHK;
            end
          end
          CMD_RELEASE: begin
            if (addr_r == 32'd0 || addr_r == NONE_FREE ||
                addr_r < 32'(heap_end_r) || !f_in_range) begin
              res_st_nxt = ST_IGNORED;
            end else begin
              state_nxt = S_REF_RD;
            end
          end
          CMD_ADD_REF, CMD_RD_REF: begin
            if (!f_in_range) res_st_nxt = ST_IGNORED;
            else state_nxt = S_REF_RD;
          end
          CMD_MARK: begin
            if (!f_in_range) res_st_nxt = ST_IGNORED;
            else state_nxt = S_MK_RD;
          end
          CMD_RESERVE: begin
            n_nxt      = rv_n;
            scan_w_nxt = '0;
            state_nxt  = S_RV_CHK;
          end
          default: res_st_nxt = ST_IGNORED;
        endcase
      end
      S_POP: begin
        ref_we        = 1'b1;
        ref_waddr     = stack_top;
        ref_wdata     = 16'd1;
        res_frame_nxt = 32'(stack_top) << 12;
        level_nxt     = level_r - LW'(1);
        state_nxt     = S_FIN;
      end
      // refill scan: one word read, then, unless the word is full, one bit per cycle
      S_SC_CHK: begin
        if (scan_w_r >= stop_w) begin
          if (got_r == LW'(0)) begin
            res_frame_nxt = NONE_FREE;
            res_st_nxt    = ST_NOFREE;
          end
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SC_LD;
        end
      end
      S_SC_LD: begin
        word_nxt = bm_rdata_r;
        bit_nxt  = 5'd0;
        if (bm_rdata_r == 32'hFFFF_FFFF) begin
          scan_w_nxt = scan_w_r + SCAN_W'(1);
          state_nxt  = S_SC_CHK;
        end else begin
          state_nxt = S_SC_BIT;
        end
      end
      S_SC_BIT: begin
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'd31) state_nxt = S_SC_WB;
        if (!word_r[bit_r]) begin
          if ((32'(scan_f) << 12) >= 32'(map_end_r)) begin
            end_nxt   = 1'b1;
            state_nxt = S_SC_WB;
          end else begin
            word_nxt[bit_r] = 1'b1;
            hint_nxt        = scan_w_r[WW-1:0];
            ref_we          = 1'b1;
            ref_waddr       = scan_f;
            ref_wdata       = 16'd1;
            if (got_r == LW'(0)) begin
              res_frame_nxt = 32'(scan_f) << 12;
            end else begin
              st_we     = 1'b1;
              level_nxt = level_r + LW'(1);
            end
            got_nxt = got_r + LW'(1);
            if (got_r == LW'(CACHE_DEPTH - 1)) begin
              end_nxt   = 1'b1;
              state_nxt = S_SC_WB;
            end
          end
        end
      end
      S_SC_WB: begin
        bm_we = 1'b1;
        if (end_r) begin
          if (got_r == LW'(0)) begin
            res_frame_nxt = NONE_FREE;
            res_st_nxt    = ST_NOFREE;
          end
          state_nxt = S_FIN;
        end else begin
          scan_w_nxt = scan_w_r + SCAN_W'(1);
          state_nxt  = S_SC_CHK;
        end
      end
      S_REF_RD: state_nxt = S_REF_EX;
      S_REF_EX: begin
        state_nxt = S_FIN;
        case (cmd_r)
          CMD_RELEASE: begin
            if (ref_rdata_r == 16'd0) begin
              res_st_nxt = ST_IGNORED;
            end else if (ref_rdata_r != 16'd1) begin
              ref_we    = 1'b1;
              ref_wdata = ref_rdata_r - 16'd1;
            end else begin
              ref_we    = 1'b1;
              ref_wdata = 16'd0;
              if (level_r < LW'(CACHE_DEPTH)) begin
                st_we     = 1'b1;
                st_wdata  = fidx;
                level_nxt = level_r + LW'(1);
              end else begin
                spill_nxt = LW'(0);
                fdone_nxt = 1'b0;
                state_nxt = S_SP_POP;
              end
            end
          end
          CMD_ADD_REF: begin
            if (ref_rdata_r != REF_MAX) begin
              ref_we    = 1'b1;
              ref_wdata = ref_rdata_r + 16'd1;
            end
          end
          default: res_ref_nxt = ref_rdata_r;
        endcase
      end
      // spill half the cache back to the bitmap, then the released frame
      S_SP_POP: begin
        clr_f_nxt = stack_top;
        level_nxt = level_r - LW'(1);
        spill_nxt = spill_r + LW'(1);
        state_nxt = S_CL_RD;
      end
      S_CL_RD: state_nxt = S_CL_WR;
      S_CL_WR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_w;
        bm_wdata = bm_rdata_r & ~(32'h1 << clr_f_r[4:0]);
        if (clr_w < hint_r && SCAN_W'(clr_w) >= low_w) begin
          hint_nxt = clr_w;
        end
        if (spill_r < LW'(CACHE_DEPTH / 2)) begin
          state_nxt = S_SP_POP;
        end else if (!fdone_r) begin
          fdone_nxt = 1'b1;
          clr_f_nxt = fidx;
          state_nxt = S_CL_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MK_RD: state_nxt = S_MK_WR;
      S_MK_WR: begin
        bm_we     = 1'b1;
        bm_waddr  = fidx[FW-1:5];
        bm_wdata  = bm_rdata_r | (32'h1 << fidx[4:0]);
        state_nxt = S_FIN;
      end
      S_RV_CHK: begin
        if (rv_base >= n_r) state_nxt = S_FIN;
        else state_nxt = S_RV_WR;
      end
      S_RV_WR: begin
        bm_we      = 1'b1;
        bm_wdata   = bm_rdata_r | rv_mask;
        scan_w_nxt = scan_w_r + SCAN_W'(1);
        state_nxt  = S_RV_CHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      level_r     <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
      heap_end_r  <= HEAP_END_RST;
      map_end_r   <= MAP_END_RST;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      level_r     <= level_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_HEAP_END: heap_end_r <= cfg_data;
          default:      map_end_r  <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    scan_w_r    <= scan_w_nxt;
    bit_r       <= bit_nxt;
    word_r      <= word_nxt;
    got_r       <= got_nxt;
    end_r       <= end_nxt;
    spill_r     <= spill_nxt;
    fdone_r     <= fdone_nxt;
    clr_f_r     <= clr_f_nxt;
    n_r         <= n_nxt;
    res_frame_r <= res_frame_nxt;
    res_ref_r   <= res_ref_nxt;
    res_st_r    <= res_st_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_frame_r <= res_frame_r;
      out_ref_r   <= res_ref_r;
      out_st_r    <= res_st_r;
    end
    if (st_we) stack_r[st_waddr] <= st_wdata;
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_rdata_r <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    ref_rdata_r <= ref_mem[fidx];
  end

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(CACHE_DEPTH))
    else $error("cache level beyond depth");

  a_got_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_BIT) |-> (got_r < LW'(CACHE_DEPTH)))
    else $error("scan continued after a full refill");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted command not dispatched");

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SCAN_W'(hint_r) < SCAN_W'(WORD_TOTAL))
    else $error("search hint out of bitmap");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;
  import pfa_pkg::*;

  localparam int FRAMES = FRAME_TOTAL_DEF;
  localparam int CDEPTH = CACHE_DEPTH_DEF;
  localparam int WORDS  = FRAMES / 32;
  localparam int LIMIT  = 4000000;

  // idle modes
  typedef enum int {IDLE_SRC, IDLE_SNK, IDLE_NONE} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = CMD_ALLOC;
  logic [31:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_frame_address;
  logic [15:0] out_ref_value;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_HEAP_END;
  logic [ADDR_REG_W-1:0] cfg_data = '0;

  page_frame_allocator DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: a private copy of the allocator's tables
  logic [31:0] used_map [WORDS];
  logic [15:0] refcnt [FRAMES];
  logic [31:0] magazine [CDEPTH];
  int unsigned mag_level;
  int unsigned hint_word;
  logic [31:0] heap_end, map_end;

  typedef struct packed {
    logic [31:0] frame;
    logic [15:0] refv;
    logic [1:0]  st;
  } beat_t;

  beat_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  int hold_off = 0;   // long receiver stall, counted down by the sink

  function automatic void clear_map_bit(int unsigned f);
    int unsigned w;
    if (f >= FRAMES) return;
    w = f >> 5;
    used_map[w][f & 31] = 1'b0;
    if (w < hint_word && w >= (heap_end >> 17)) hint_word = w;
  endfunction

  // computes the result of one command and updates the model tables
  function automatic beat_t predict_command(logic [2:0] cmd, logic [31:0] addr);
    beat_t r;
    int unsigned f, lo, start, stop, got, g;
    longint unsigned n;
    bit done;
    f = addr >> 12;
    r = '{frame: 32'd0, refv: 16'd0, st: ST_DONE};
    case (cmd)
      CMD_ALLOC: begin
        if (mag_level > 0) begin
          mag_level--;
          g = magazine[mag_level];
          if (g < FRAMES) refcnt[g] = 16'd1;
          r.frame = g * 4096;
        end else begin
          got = 0;
          done = 1'b0;
          lo = heap_end >> 17;
          start = (hint_word < lo) ? lo : hint_word;
          stop = map_end >> 17;
          if (stop > WORDS) stop = WORDS;
          for (int unsigned i = start; i < stop && got < CDEPTH && !done; i++) begin
            for (int unsigned j = 0; j < 32 && got < CDEPTH && !done; j++) begin
              if (!used_map[i][j]) begin
                g = i * 32 + j;
                if (longint'(g) * 4096 >= map_end) done = 1'b1;
                else begin
                  used_map[i][j] = 1'b1;
                  hint_word = i;
                  refcnt[g] = 16'd1;
                  if (got == 0) r.frame = g * 4096;
                  else magazine[got - 1] = g;
                  got++;
                end
              end
            end
          end
          if (got == 0) begin
            r.frame = NONE_FREE;
            r.st = ST_NOFREE;
          end else mag_level = got - 1;
        end
      end
      CMD_RELEASE: begin
        if (addr == 0 || addr == NONE_FREE || addr < heap_end || f >= FRAMES ||
            refcnt[f] == 0) begin
          r.st = ST_IGNORED;
        end else if (refcnt[f] > 1) begin
          refcnt[f]--;
        end else begin
          refcnt[f] = 16'd0;
          if (mag_level < CDEPTH) begin
            magazine[mag_level] = f;
            mag_level++;
          end else begin
            // full magazine: spill the top half back to the bitmap
            for (int k = 0; k < CDEPTH / 2; k++) begin
              mag_level--;
              clear_map_bit(magazine[mag_level]);
            end
            clear_map_bit(f);
          end
        end
      end
      CMD_ADD_REF: begin
        if (f >= FRAMES) r.st = ST_IGNORED;
        else if (refcnt[f] != REF_MAX) refcnt[f]++;
      end
      CMD_RD_REF: begin
        if (f >= FRAMES) r.st = ST_IGNORED;
        else r.refv = refcnt[f];
      end
      CMD_MARK: begin
        if (f >= FRAMES) r.st = ST_IGNORED;
        else used_map[f >> 5][f & 31] = 1'b1;
      end
      CMD_RESERVE: begin
        n = (longint'(addr) + 4095) >> 12;
        if (n > FRAMES) n = FRAMES;
        for (int unsigned k = 0; k < n; k++) used_map[k >> 5][k & 31] = 1'b1;
      end
      default: r.st = ST_IGNORED;
    endcase
    return r;
  endfunction

  function automatic bit src_idles();
    return idle_mode == IDLE_SRC ? ($urandom_range(99) < 12) :
           idle_mode == IDLE_SNK ? ($urandom_range(99) < 60) : 1'b0;
  endfunction

  // send one command beat; predict at acceptance. valid stays up until the
  // next beat or drain takes it down at the following falling edge.
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] addr);
    while (src_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_command(cmd, addr));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ADDR_REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HEAP_END) heap_end = val;
    else map_end = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // sink: random stalls per mode plus the long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else
      out_ready <= idle_mode == IDLE_SRC ? ($urandom_range(99) >= 60) :
                   idle_mode == IDLE_SNK ? ($urandom_range(99) >= 12) : 1'b1;
  end

  // checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    beat_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_frame_address !== exp_r.frame) begin
          $error("frame_address exp %h got %h", exp_r.frame, out_frame_address);
          errors++;
        end
        if (out_ref_value !== exp_r.refv) begin
          $error("ref_value exp %h got %h", exp_r.refv, out_ref_value);
          errors++;
        end
        if (out_status !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // addresses mostly within the frame range, with some random, zero and none-free values
  function automatic logic [31:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom();
    if (sel == 1) return 32'h0;
    if (sel == 2) return NONE_FREE;
    return ($urandom_range(FRAMES - 1) << 12) | $urandom_range(4095);
  endfunction

  task automatic test_directed();
    write_reg(REG_HEAP_END, 27'h40_0000);
    write_reg(REG_MAP_END, 27'h400_0000);
    send_cmd(CMD_ALLOC, 32'h0);
    send_cmd(CMD_ALLOC, 32'h0);
    send_cmd(CMD_ADD_REF, 32'h0040_0000);
    send_cmd(CMD_RD_REF, 32'h0040_0000);
    send_cmd(CMD_RELEASE, 32'h0040_0000);
    send_cmd(CMD_RELEASE, 32'h0040_0000);
    send_cmd(CMD_RELEASE, 32'h0040_0000);   // already zero
    send_cmd(CMD_RELEASE, 32'h0);
    send_cmd(CMD_RELEASE, NONE_FREE);
    send_cmd(CMD_RELEASE, 32'h0000_1000);   // below heap end
    send_cmd(CMD_RELEASE, 32'h0400_0000);   // out of range
    send_cmd(CMD_RD_REF, NONE_FREE);
    send_cmd(CMD_ADD_REF, 32'hFFFF_F000);
    send_cmd(CMD_MARK, 32'h8000_0000);
    send_cmd(CMD_MARK, 32'h0050_0000);
    send_cmd(CMD_RESERVE, 32'h0000_2001);
    send_cmd(3'd6, 32'h0);
    send_cmd(3'd7, NONE_FREE);
    // repeated add reference on one frame
    for (int i = 0; i < 3; i++) send_cmd(CMD_ADD_REF, 32'h0000_3000);
    drain();
  endtask

  // allocate frames, then release them all so the magazine fills and spills
  task automatic test_spill();
    logic [31:0] held[$];
    beat_t b;
    for (int i = 0; i < 2 * CDEPTH + 2; i++) begin
      send_cmd(CMD_ALLOC, 32'h0);
      b = pending_results[$];
      if (b.st == ST_DONE) held.push_back(b.frame);
    end
    foreach (held[k]) send_cmd(CMD_RELEASE, held[k]);
    drain();
  endtask

  task automatic test_random(int count);
    int unsigned c;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(99);
      if (c < 35) send_cmd(CMD_ALLOC, $urandom());
      else if (c < 65) send_cmd(CMD_RELEASE, pick_addr());
      else if (c < 75) send_cmd(CMD_ADD_REF, pick_addr());
      else if (c < 85) send_cmd(CMD_RD_REF, pick_addr());
      else if (c < 93) send_cmd(CMD_MARK, pick_addr());
      else if (c < 97) send_cmd(CMD_RESERVE, $urandom_range(32'h0060_0000));
      else send_cmd(3'($urandom_range(7)), $urandom());
    end
    drain();
  endtask

  // long sink stall while the source keeps pushing
  task automatic test_backpressure();
    hold_off <= 400;
    for (int i = 0; i < 12; i++) send_cmd(CMD_RD_REF, pick_addr());
    drain();
  endtask

  task automatic test_config_sweep();
    // narrow window near the bottom of memory, then tiny map end
    write_reg(REG_HEAP_END, 27'h0);
    write_reg(REG_MAP_END, 27'h2_0000);
    test_random(60);
    write_reg(REG_MAP_END, 27'h0);
    send_cmd(CMD_ALLOC, 32'h0);
    drain();
    write_reg(REG_HEAP_END, 27'h7FF_FFFF);
    write_reg(REG_MAP_END, 27'h7FF_FFFF);
    test_random(40);
    write_reg(REG_HEAP_END, 27'h10_1000);
    write_reg(REG_MAP_END, 27'h200_0000);
    test_random(100);
  endtask

  initial begin
    for (int i = 0; i < WORDS; i++) used_map[i] = '0;
    for (int i = 0; i < FRAMES; i++) refcnt[i] = '0;
    for (int i = 0; i < CDEPTH; i++) magazine[i] = '0;
    mag_level = 0;
    hint_word = 0;
    heap_end = HEAP_END_RST;
    map_end = MAP_END_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_mode = IDLE_SRC;
    test_directed();
    test_spill();
    test_random(250);
    idle_mode = IDLE_SNK;
    test_backpressure();
    test_config_sweep();
    idle_mode = IDLE_NONE;
    write_reg(REG_HEAP_END, 27'h40_0000);
    write_reg(REG_MAP_END, 27'h400_0000);
    test_random(300);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/pfa_pkg.sv
src/page_frame_allocator.sv
verif/tb_top.sv
